// File: sv/cwcm_pkg.sv
// Package for the cylindrical warp coordinate map.
// Beat types, register indexes and fixed-point constants; no dependencies.
package cwcm_pkg;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
  } in_t;

  typedef struct packed {
    logic        inside_res;
    logic [11:0] src_col;
    logic [11:0] src_row;
    logic [15:0] frac_col;
    logic [15:0] frac_row;
    logic [16:0] weight_top_left;
    logic [16:0] weight_top_right;
    logic [16:0] weight_bottom_left;
    logic [16:0] weight_bottom_right;
  } out_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FOCAL_LENGTH = 2'd2
  } cfg_reg_t;

  localparam int IDX_W = 2;
  localparam int CFG_W = 16;

  localparam logic [12:0] RST_WIDTH  = 13'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;
  localparam logic [15:0] RST_FOCAL  = 16'd1100;

  // Q2.30 fixed point
  localparam logic [31:0] QONE      = 32'h4000_0000;
  localparam logic [29:0] RND_Q30   = 30'h2000_0000;
  localparam logic [30:0] ANGLE_MAX = 31'h6000_0000;
  localparam logic [30:0] COS_MIN   = 31'h0400_0000;
  localparam int          NSTEP     = 10;

  // side data carried with a beat
  typedef struct packed {
    logic bad;
    logic sx;
    logic sy;
  } flag_t;

  typedef struct packed {
    flag_t       flag;
    logic [11:0] ady;
  } front_side_t;

endpackage

// File: sv/cwcm_div.sv
// Pipelined restoring divider, one quotient bit per stage, side data carried along.
// Depends on nothing; used for the angle, tangent and secant quotients.
module cwcm_div #(
  parameter int NUM_W  = 43,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              vout,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);
  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic              v   [1:QUO_W];
  logic [CW-1:0]     rem [1:QUO_W];
  logic [DEN_W-1:0]  dv  [1:QUO_W];
  logic [QUO_W-1:0]  qv  [1:QUO_W];
  logic [SIDE_W-1:0] sv  [1:QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_bit
    localparam int B = QUO_W - 1 - i;
    logic              cur_v;
    logic [CW-1:0]     cur_rem;
    logic [DEN_W-1:0]  cur_den;
    logic [QUO_W-1:0]  cur_q;
    logic [SIDE_W-1:0] cur_side;
    logic [CW-1:0]     sub;
    logic              ge;

    if (i == 0) begin : g_first
      assign cur_v    = vin;
      assign cur_rem  = CW'(num);
      assign cur_den  = den;
      assign cur_q    = '0;
      assign cur_side = side;
    end else begin : g_next
      assign cur_v    = v[i];
      assign cur_rem  = rem[i];
      assign cur_den  = dv[i];
      assign cur_q    = qv[i];
      assign cur_side = sv[i];
    end

    assign sub = CW'(cur_den) << B;
    assign ge  = cur_rem >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? cur_rem - sub : cur_rem;
        dv[i+1]  <= cur_den;
        qv[i+1]  <= cur_q | (QUO_W'(ge) << B);
        sv[i+1]  <= cur_side;
      end
    end
  end

  assign vout     = v[QUO_W];
  assign quo      = qv[QUO_W];
  assign side_out = sv[QUO_W];

endmodule

// File: sv/cwcm_step.sv
// One Horner step of the cosine and sine series: c = 1 - round(a2*c)/d, clamped at zero.
// Four stages: multiply-add, reciprocal multiply, remainder, correction. Uses cwcm_pkg.
module cwcm_step #(
  parameter int K      = 1,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [30:0]       a,
  input  logic [31:0]       a2,
  input  logic [30:0]       c,
  input  logic [30:0]       s,
  input  logic [SIDE_W-1:0] side,
  output logic              vout,
  output logic [30:0]       a_out,
  output logic [31:0]       a2_out,
  output logic [30:0]       c_out,
  output logic [30:0]       s_out,
  output logic [SIDE_W-1:0] side_out
);
  localparam longint unsigned DC = (2 * K - 1) * (2 * K);
  localparam longint unsigned DS = (2 * K) * (2 * K + 1);
  localparam longint unsigned MC = 64'h1_0000_0000 / DC;
  localparam longint unsigned MS = 64'h1_0000_0000 / DS;
  localparam logic [29:0] RND_Q30_W = cwcm_pkg::RND_Q30;

  logic              va, vb, vc;
  logic [30:0]       a_a, a_b, a_c;
  logic [31:0]       a2_a, a2_b, a2_c;
  logic [SIDE_W-1:0] sd_a, sd_b, sd_c;
  logic [62:0]       pc, ps;
  logic [31:0]       pqc, pqs;
  logic [63:0]       mc, ms;
  logic [31:0]       qc, qs, rc, rs;
  logic [31:0]       tc, ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      vc   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      va   <= vin;
      vb   <= va;
      vc   <= vb;
      vout <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_a  <= a;
      a2_a <= a2;
      sd_a <= side;
      pc   <= 63'(a2) * 63'(c) + 63'(RND_Q30_W);
      ps   <= 63'(a2) * 63'(s) + 63'(RND_Q30_W);

      a_b  <= a_a;
      a2_b <= a2_a;
      sd_b <= sd_a;
      pqc  <= pc[61:30];
      pqs  <= ps[61:30];
      mc   <= 64'(pc[61:30]) * 64'(MC);
      ms   <= 64'(ps[61:30]) * 64'(MS);

      // reciprocal estimate is exact or one short
      a_c  <= a_b;
      a2_c <= a2_b;
      sd_c <= sd_b;
      qc   <= mc[63:32];
      qs   <= ms[63:32];
      rc   <= pqc - 32'(mc[63:32] * 32'(DC));
      rs   <= pqs - 32'(ms[63:32] * 32'(DS));

      a_out    <= a_c;
      a2_out   <= a2_c;
      side_out <= sd_c;
      c_out    <= (tc > cwcm_pkg::QONE) ? '0 : 31'(cwcm_pkg::QONE - tc);
      s_out    <= (ts > cwcm_pkg::QONE) ? '0 : 31'(cwcm_pkg::QONE - ts);
    end
  end

  assign tc = qc + {31'b0, rc >= 32'(DC)};
  assign ts = qs + {31'b0, rs >= 32'(DS)};

endmodule

// File: sv/cwcm_trig.sv
// Cosine and sine of the angle in Q2.30: square, ten series steps, final multiply by a.
// Depends on cwcm_pkg and cwcm_step.
module cwcm_trig #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [30:0]       a,
  input  logic [SIDE_W-1:0] side,
  output logic              vout,
  output logic [30:0]       cos_q,
  output logic [30:0]       sin_q,
  output logic [SIDE_W-1:0] side_out
);
  localparam int NS = cwcm_pkg::NSTEP;

  logic              v1;
  logic [30:0]       a1;
  logic [61:0]       sq1;
  logic [SIDE_W-1:0] sd1;
  logic [30:0]       cf;
  logic [60:0]       pf;

  wire              vw  [0:NS];
  wire [30:0]       aw  [0:NS];
  wire [31:0]       a2w [0:NS];
  wire [30:0]       cw  [0:NS];
  wire [30:0]       sw  [0:NS];
  wire [SIDE_W-1:0] sdw [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      vout <= vw[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1       <= a;
      sd1      <= side;
      sq1      <= 62'(a) * 62'(a) + 62'(cwcm_pkg::RND_Q30);
      cf       <= cw[NS];
      pf       <= 61'(aw[NS]) * 61'(sw[NS]) + 61'(cwcm_pkg::RND_Q30);
      side_out <= sdw[NS];
    end
  end

  assign vw[0]  = v1;
  assign aw[0]  = a1;
  assign a2w[0] = sq1[61:30];
  assign cw[0]  = 31'(cwcm_pkg::QONE);
  assign sw[0]  = 31'(cwcm_pkg::QONE);
  assign sdw[0] = sd1;

  for (genvar j = 0; j < NS; j++) begin : g_step
    cwcm_step #(.K(NS - j), .SIDE_W(SIDE_W)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vin      (vw[j]),
      .a        (aw[j]),
      .a2       (a2w[j]),
      .c        (cw[j]),
      .s        (sw[j]),
      .side     (sdw[j]),
      .vout     (vw[j+1]),
      .a_out    (aw[j+1]),
      .a2_out   (a2w[j+1]),
      .c_out    (cw[j+1]),
      .s_out    (sw[j+1]),
      .side_out (sdw[j+1])
    );
  end

  assign cos_q = cf;
  assign sin_q = pf[60:30];

endmodule

// File: sv/cwcm_bilin.sv
// Inside test, floor and fraction split, bilinear weights and the output register.
// Depends on cwcm_pkg.
module cwcm_bilin #(
  parameter int FRAC_BITS = 16,
  parameter int PX_W      = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vin,
  input  logic                   bad,
  input  logic signed [PX_W-1:0] px,
  input  logic signed [PX_W-1:0] py,
  input  logic signed [16:0]     lim_c,
  input  logic signed [16:0]     lim_r,
  output logic                   vout,
  output cwcm_pkg::out_t         res
);
  localparam int COL_W = PX_W - FRAC_BITS;
  localparam int CMP_W = ((COL_W > 17) ? COL_W : 17) + 1;

  logic signed [COL_W-1:0] col, row;
  logic                    col_ok, row_ok, ins;
  logic [15:0]             fxc, fyc;

  logic        v1, v2;
  logic        in1, in2;
  logic [11:0] col1, row1, col2, row2;
  logic [15:0] fx1, fy1, fx2, fy2;
  logic [16:0] gx, gy;
  logic [33:0] ptl, ptr, pbl, pbr;

  assign col    = px[PX_W-1:FRAC_BITS];
  assign row    = py[PX_W-1:FRAC_BITS];
  assign col_ok = CMP_W'(col) <= CMP_W'(lim_c);
  assign row_ok = CMP_W'(row) <= CMP_W'(lim_r);
  assign ins    = !bad && !px[PX_W-1] && !py[PX_W-1] && col_ok && row_ok;

  if (FRAC_BITS >= 16) begin : g_trunc
    assign fxc = px[FRAC_BITS-1 -: 16];
    assign fyc = py[FRAC_BITS-1 -: 16];
  end else begin : g_pad
    assign fxc = {px[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
    assign fyc = {py[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
  end

  assign gx = 17'h10000 - 17'(fx1);
  assign gy = 17'h10000 - 17'(fy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      vout <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in1  <= ins;
      col1 <= col[11:0];
      row1 <= row[11:0];
      fx1  <= fxc;
      fy1  <= fyc;

      in2  <= in1;
      col2 <= col1;
      row2 <= row1;
      fx2  <= fx1;
      fy2  <= fy1;
      ptl  <= 34'(gx) * 34'(gy);
      ptr  <= 34'(fx1) * 34'(gy);
      pbl  <= 34'(gx) * 34'(fy1);
      pbr  <= 34'(fx1) * 34'(fy1);

      // zero every field of a beat that falls outside
      if (in2) begin
        res.inside_res          <= 1'b1;
        res.src_col             <= col2;
        res.src_row             <= row2;
        res.frac_col            <= fx2;
        res.frac_row            <= fy2;
        res.weight_top_left     <= 17'((ptl + 34'd32768) >> 16);
        res.weight_top_right    <= 17'((ptr + 34'd32768) >> 16);
        res.weight_bottom_left  <= 17'((pbl + 34'd32768) >> 16);
        res.weight_bottom_right <= 17'((pbr + 34'd32768) >> 16);
      end else begin
        res <= '0;
      end
    end
  end

endmodule

// File: sv/cylindrical_warp_coordinate_map.sv
// Top level of the cylindrical warp coordinate map.
// Depends on cwcm_pkg, cwcm_div, cwcm_step, cwcm_trig and cwcm_bilin.
//
//   port group        | direction | beat
//   ------------------+-----------+-------------------------------------
//   in_valid/in_stall | input     | in_data  : dest_x, dest_y
//   out_valid/stall   | output    | out_data : inside flag, floors, fractions, weights
//   cfg_en/index/data | input     | width, height, focal length
//
// One beat enters per cycle while the output is not stalled. The path runs through 31 angle
// divider stages, 42 trig stages, 35 tangent/secant divider stages and the surrounding stages.
// Synchronous reset clears the valid bits and loads the register defaults.
// The whole pipe holds while the output beat is stalled; in_stall then rises.
module cylindrical_warp_coordinate_map #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cwcm_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cwcm_pkg::out_t               out_data,
  input  logic                         cfg_en,
  input  logic [cwcm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cwcm_pkg::CFG_W-1:0]   cfg_data
);
  localparam int SH    = 30 - FRAC_BITS;
  localparam int OFF_W = 52 - SH;
  localparam int PX_W  = OFF_W + 2;
  localparam logic [51:0] RND_OFF = 52'(1) << (29 - FRAC_BITS);

  logic        en;
  logic [12:0] image_width, image_height;
  logic [15:0] focal_length;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= cwcm_pkg::RST_WIDTH;
      image_height <= cwcm_pkg::RST_HEIGHT;
      focal_length <= cwcm_pkg::RST_FOCAL;
    end else if (cfg_en) begin
      unique case (cfg_index)
        cwcm_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        cwcm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        cwcm_pkg::REG_FOCAL_LENGTH: focal_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // saturated size and centre
  logic [15:0]        w_sat, h_sat;
  logic [12:0]        cx, cy;
  logic signed [16:0] lim_c, lim_r;

  assign w_sat = ({3'b0, image_width} > 16'(MAX_DIM)) ? 16'(MAX_DIM) : {3'b0, image_width};
  assign h_sat = ({3'b0, image_height} > 16'(MAX_DIM)) ? 16'(MAX_DIM) : {3'b0, image_height};
  assign cx    = 13'(w_sat >> 1);
  assign cy    = 13'(h_sat >> 1);
  assign lim_c = $signed({1'b0, w_sat}) - 17'sd2;
  assign lim_r = $signed({1'b0, h_sat}) - 17'sd2;

  // front stage: offsets from centre and the angle numerator
  logic signed [13:0]    dx, dy;
  logic [11:0]           adx, ady;
  logic [42:0]           num_a;
  logic [46:0]           ang_lim;
  logic                  p_v;
  logic [42:0]           p_num;
  cwcm_pkg::front_side_t p_side;

  assign dx      = $signed(14'(in_data.dest_x)) - $signed(14'(cx));
  assign dy      = $signed(14'(in_data.dest_y)) - $signed(14'(cy));
  assign adx     = dx[13] ? 12'(-dx) : 12'(dx);
  assign ady     = dy[13] ? 12'(-dy) : 12'(dy);
  assign num_a   = {1'b0, adx, 30'b0} + 43'(focal_length >> 1);
  assign ang_lim = 47'(cwcm_pkg::ANGLE_MAX) * 47'(focal_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num           <= num_a;
      p_side.flag.bad <= (focal_length == '0) || (47'(num_a) >= ang_lim);
      p_side.flag.sx  <= dx[13];
      p_side.flag.sy  <= dy[13];
      p_side.ady      <= ady;
    end
  end

  // angle divider
  logic                  ad_v;
  logic [30:0]           ad_q;
  cwcm_pkg::front_side_t ad_side;

  cwcm_div #(.NUM_W(43), .DEN_W(16), .QUO_W(31),
             .SIDE_W($bits(cwcm_pkg::front_side_t))) u_div_ang (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (p_v),
    .num      (p_num),
    .den      (focal_length),
    .side     (p_side),
    .vout     (ad_v),
    .quo      (ad_q),
    .side_out (ad_side)
  );

  // cosine and sine
  logic                  tr_v;
  logic [30:0]           cos_q, sin_q;
  cwcm_pkg::front_side_t tr_side;

  cwcm_trig #(.SIDE_W($bits(cwcm_pkg::front_side_t))) u_trig (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (ad_v),
    .a        (ad_q),
    .side     (ad_side),
    .vout     (tr_v),
    .cos_q    (cos_q),
    .sin_q    (sin_q),
    .side_out (tr_side)
  );

  // tangent and secant numerators
  logic            t_v;
  logic [61:0]     t_num_tan, t_num_sec;
  logic [30:0]     t_den;
  cwcm_pkg::flag_t t_flag;
  logic [11:0]     t_ady;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else if (en) begin
      t_v <= tr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_num_tan   <= (62'(sin_q) << 30) + 62'(cos_q >> 1);
      t_num_sec   <= (62'(1) << 60) + 62'(cos_q >> 1);
      t_den       <= cos_q;
      t_flag.sx   <= tr_side.flag.sx;
      t_flag.sy   <= tr_side.flag.sy;
      t_flag.bad  <= tr_side.flag.bad || (cos_q < cwcm_pkg::COS_MIN);
      t_ady       <= tr_side.ady;
    end
  end

  logic            dt_v, ds_v;
  logic [34:0]     tan_q, sec_q;
  cwcm_pkg::flag_t dt_flag;
  logic [11:0]     ds_ady;

  cwcm_div #(.NUM_W(62), .DEN_W(31), .QUO_W(35),
             .SIDE_W($bits(cwcm_pkg::flag_t))) u_div_tan (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (t_v),
    .num      (t_num_tan),
    .den      (t_den),
    .side     (t_flag),
    .vout     (dt_v),
    .quo      (tan_q),
    .side_out (dt_flag)
  );

  cwcm_div #(.NUM_W(62), .DEN_W(31), .QUO_W(35), .SIDE_W(12)) u_div_sec (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (t_v),
    .num      (t_num_sec),
    .den      (t_den),
    .side     (t_ady),
    .vout     (ds_v),
    .quo      (sec_q),
    .side_out (ds_ady)
  );

  // offsets in pixels
  logic            o_v;
  logic [50:0]     o_prodx;
  logic [46:0]     o_prody;
  cwcm_pkg::flag_t o_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= dt_v && ds_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_prodx <= 51'(focal_length) * 51'(tan_q);
      o_prody <= 47'(ds_ady) * 47'(sec_q);
      o_flag  <= dt_flag;
    end
  end

  // source position in Q.FRAC_BITS
  logic [51:0]            sum_x, sum_y;
  logic signed [PX_W-1:0] off_x, off_y, base_x, base_y;
  logic                   q_v, q_bad;
  logic signed [PX_W-1:0] q_px, q_py;

  assign sum_x  = 52'(o_prodx) + RND_OFF;
  assign sum_y  = 52'(o_prody) + RND_OFF;
  assign off_x  = $signed(PX_W'(sum_x[51:SH]));
  assign off_y  = $signed(PX_W'(sum_y[51:SH]));
  assign base_x = $signed(PX_W'(cx) << FRAC_BITS);
  assign base_y = $signed(PX_W'(cy) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (en) begin
      q_v <= o_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_px  <= o_flag.sx ? base_x - off_x : base_x + off_x;
      q_py  <= o_flag.sy ? base_y - off_y : base_y + off_y;
      q_bad <= o_flag.bad;
    end
  end

  cwcm_bilin #(.FRAC_BITS(FRAC_BITS), .PX_W(PX_W)) u_bilin (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vin   (q_v),
    .bad   (q_bad),
    .px    (q_px),
    .py    (q_py),
    .lim_c (lim_c),
    .lim_r (lim_r),
    .vout  (out_valid),
    .res   (out_data)
  );

  // checks
  logic [18:0] wsum;

  assign wsum = 19'(out_data.weight_top_left) + 19'(out_data.weight_top_right) +
                19'(out_data.weight_bottom_left) + 19'(out_data.weight_bottom_right);

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output beat");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.inside_res) |->
      (out_data.src_col == '0 && out_data.src_row == '0 &&
       out_data.frac_col == '0 && out_data.frac_row == '0 &&
       out_data.weight_top_left == '0 && out_data.weight_top_right == '0 &&
       out_data.weight_bottom_left == '0 && out_data.weight_bottom_right == '0))
    else $error("outside beat carries nonzero fields");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.inside_res) |-> (wsum >= 19'd65534 && wsum <= 19'd65538))
    else $error("bilinear weights do not sum to one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat valid right after reset");

endmodule

// File: verif/cylindrical_warp_coordinate_map_chk.sv
// Checker for the cylindrical warp coordinate map: predicts each output beat from the
// input beat and the register copy, and compares field by field. Depends on cwcm_pkg.
module cylindrical_warp_coordinate_map_chk (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  cwcm_pkg::in_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  cwcm_pkg::out_t             out_data,
  input  logic                       cfg_en,
  input  logic [cwcm_pkg::IDX_W-1:0] cfg_index,
  input  logic [cwcm_pkg::CFG_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         inside_seen
);
  localparam logic [63:0] Q1 = 64'd1 << 30;
  localparam logic [63:0] QH = 64'd1 << 29;

  logic [12:0]    width_reg;
  logic [12:0]    height_reg;
  logic [15:0]    focal_reg;
  cwcm_pkg::out_t mapped_q[$];
  int             beat_num;

  function automatic logic [63:0] qmul30(logic [63:0] x, logic [63:0] y);
    return (x * y + QH) >> 30;
  endfunction

  function automatic cwcm_pkg::out_t map_coord(cwcm_pkg::in_t d, logic [12:0] wr,
                                               logic [12:0] hr, logic [15:0] fr);
    cwcm_pkg::out_t r;
    logic [63:0] w, h, f, adx, ady, ang, ang2, c, s, t, n, tanq, secq, offx, offy;
    logic [63:0] fx, fy, gx, gy;
    longint      cx, cy, dx, dy, px, py, col, row;
    r = '0;
    w = (wr > 4096) ? 64'd4096 : 64'(wr);
    h = (hr > 4096) ? 64'd4096 : 64'(hr);
    f = 64'(fr);
    cx = longint'(w / 2);
    cy = longint'(h / 2);
    dx = longint'(d.dest_x) - cx;
    dy = longint'(d.dest_y) - cy;
    adx = 64'(dx < 0 ? -dx : dx);
    ady = 64'(dy < 0 ? -dy : dy);
    if (f == 0) return r;
    ang = ((adx << 30) + f / 2) / f;
    if (ang >= 64'd1610612736) return r;
    ang2 = qmul30(ang, ang);
    c = Q1;
    s = Q1;
    for (int k = 10; k >= 1; k--) begin
      n = 64'(2 * k);
      t = qmul30(ang2, c) / ((n - 1) * n);
      c = (t > Q1) ? 64'd0 : Q1 - t;
      t = qmul30(ang2, s) / (n * (n + 1));
      s = (t > Q1) ? 64'd0 : Q1 - t;
    end
    s = qmul30(ang, s);
    if (c < (Q1 >> 4)) return r;
    tanq = ((s << 30) + c / 2) / c;
    secq = ((64'd1 << 60) + c / 2) / c;
    offx = (f * tanq + (64'd1 << 13)) >> 14;
    offy = (ady * secq + (64'd1 << 13)) >> 14;
    px = cx <<< 16;
    py = cy <<< 16;
    px = (dx < 0) ? px - longint'(offx) : px + longint'(offx);
    py = (dy < 0) ? py - longint'(offy) : py + longint'(offy);
    if (px < 0 || py < 0) return r;
    col = px >>> 16;
    row = py >>> 16;
    if (col > longint'(w) - 2 || row > longint'(h) - 2) return r;
    fx = 64'(px) & 64'hFFFF;
    fy = 64'(py) & 64'hFFFF;
    gx = 65536 - fx;
    gy = 65536 - fy;
    r.inside_res          = 1'b1;
    r.src_col             = col[11:0];
    r.src_row             = row[11:0];
    r.frac_col            = fx[15:0];
    r.frac_row            = fy[15:0];
    r.weight_top_left     = 17'((gx * gy + 32768) >> 16);
    r.weight_top_right    = 17'((fx * gy + 32768) >> 16);
    r.weight_bottom_left  = 17'((gx * fy + 32768) >> 16);
    r.weight_bottom_right = 17'((fx * fy + 32768) >> 16);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch beat %0d %s: got %0d want %0d", beat_num, what, got, want);
    errors++;
  endtask

  assign pending = mapped_q.size();

  always @(posedge clk) begin
    cwcm_pkg::out_t want;
    if (rst) begin
      width_reg   <= cwcm_pkg::RST_WIDTH;
      height_reg  <= cwcm_pkg::RST_HEIGHT;
      focal_reg   <= cwcm_pkg::RST_FOCAL;
      errors      = 0;
      inside_seen = 0;
      beat_num    = 0;
    end else begin
      if (cfg_en) begin
        case (cwcm_pkg::cfg_reg_t'(cfg_index))
          cwcm_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[12:0];
          cwcm_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[12:0];
          cwcm_pkg::REG_FOCAL_LENGTH: focal_reg  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        mapped_q = {mapped_q, map_coord(in_data, width_reg, height_reg, focal_reg)};
      if (out_valid && !out_stall) begin
        if (mapped_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = mapped_q.pop_front();
          if (want.inside_res) inside_seen++;
          if (out_data.inside_res !== want.inside_res)
            report_mismatch("inside_res", out_data.inside_res, want.inside_res);
          if (out_data.src_col !== want.src_col)
            report_mismatch("src_col", out_data.src_col, want.src_col);
          if (out_data.src_row !== want.src_row)
            report_mismatch("src_row", out_data.src_row, want.src_row);
          if (out_data.frac_col !== want.frac_col)
            report_mismatch("frac_col", out_data.frac_col, want.frac_col);
          if (out_data.frac_row !== want.frac_row)
            report_mismatch("frac_row", out_data.frac_row, want.frac_row);
          if (out_data.weight_top_left !== want.weight_top_left)
            report_mismatch("weight_top_left", out_data.weight_top_left,
                            want.weight_top_left);
          if (out_data.weight_top_right !== want.weight_top_right)
            report_mismatch("weight_top_right", out_data.weight_top_right,
                            want.weight_top_right);
          if (out_data.weight_bottom_left !== want.weight_bottom_left)
            report_mismatch("weight_bottom_left", out_data.weight_bottom_left,
                            want.weight_bottom_left);
          if (out_data.weight_bottom_right !== want.weight_bottom_right)
            report_mismatch("weight_bottom_right", out_data.weight_bottom_right,
                            want.weight_bottom_right);
        end
        beat_num++;
      end
    end
  end
endmodule

// File: verif/cylindrical_warp_coordinate_map_tb.sv
// Testbench top for the cylindrical warp coordinate map: drives coordinates and
// register writes, and gives the verdict. Depends on cwcm_pkg, the top level and the checker module.
module cylindrical_warp_coordinate_map_tb;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  cwcm_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  cwcm_pkg::out_t                 out_data;
  logic                           cfg_en = 1'b0;
  logic [cwcm_pkg::IDX_W-1:0]     cfg_index = '0;
  logic [cwcm_pkg::CFG_W-1:0]     cfg_data = '0;
  int                             errors, pending, inside_seen;
  int                             send_idle_pct = 0;
  int                             stall_pct = 0;
  int                             hold_cycles = 0;
  int                             sent = 0;

  always #1 clk = ~clk;

  cylindrical_warp_coordinate_map DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cylindrical_warp_coordinate_map_chk u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .inside_seen(inside_seen)
  );

  // Receiver: random stall, or a long hold-off counted here.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one beat, with random idle cycles first; hold until accepted.
  task automatic send_coord(logic [11:0] x, logic [11:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{dest_x: x, dest_y: y};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Drop valid and wait until every beat in flight has come out.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (170) @(negedge clk);
  endtask

  task automatic write_reg(cwcm_pkg::cfg_reg_t idx, logic [cwcm_pkg::CFG_W-1:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_en    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(logic [12:0] w, logic [12:0] h, logic [15:0] f);
    write_reg(cwcm_pkg::REG_IMAGE_WIDTH, 16'(w));
    write_reg(cwcm_pkg::REG_IMAGE_HEIGHT, 16'(h));
    write_reg(cwcm_pkg::REG_FOCAL_LENGTH, f);
  endtask

  // Mostly points near the image, some anywhere in the 12-bit range.
  task automatic send_random(int count, int w, int h);
    logic [11:0] x, y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        x = 12'($urandom);
        y = 12'($urandom);
      end else begin
        x = 12'($urandom_range((w > 4095) ? 4095 : w));
        y = 12'($urandom_range((h > 4095) ? 4095 : h));
      end
      send_coord(x, y);
    end
  endtask

  initial begin
    int w, h;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corners, center, near right angle, under reset values.
    send_coord(12'd0, 12'd0);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd320, 12'd240);
    send_coord(12'd639, 12'd479);
    send_coord(12'd638, 12'd478);
    send_coord(12'd0, 12'd4095);
    send_coord(12'd4095, 12'd0);
    send_coord(12'd2047, 12'd2048);
    drain_pipe();
    // zero focal length
    set_geometry(13'd640, 13'd480, 16'd0);
    send_coord(12'd320, 12'd240);
    send_coord(12'd100, 12'd50);
    drain_pipe();
    // tiny image, oversize image (saturates), unknown index ignored
    set_geometry(13'd1, 13'd0, 16'd500);
    send_coord(12'd0, 12'd0);
    send_coord(12'd1, 12'd1);
    drain_pipe();
    write_reg(cwcm_pkg::cfg_reg_t'(2'd3), 16'hFFFF);
    set_geometry(13'h1FFF, 13'h1FFF, 16'hFFFF);
    send_coord(12'd2048, 12'd2048);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd0, 12'd0);
    drain_pipe();
    // small focal length on a two-by-two image
    set_geometry(13'd2, 13'd2, 16'd1);
    send_coord(12'd1, 12'd1);
    send_coord(12'd2, 12'd0);
    send_coord(12'd0, 12'd1);
    drain_pipe();
    set_geometry(13'd4096, 13'd4096, 16'd1400);
    send_coord(12'd4095, 12'd2048);
    send_coord(12'd0, 12'd2048);
    send_coord(12'd3400, 12'd100);
    drain_pipe();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      case (phase)
        0: begin w = 640;  h = 480;  set_geometry(13'd640, 13'd480, 16'd1100); end
        1: begin w = 2;    h = 2;    set_geometry(13'd2, 13'd2, 16'd3); end
        2: begin w = 4096; h = 4096; set_geometry(13'd4096, 13'd4096, 16'd65535); end
        3: begin w = 1000; h = 300;  set_geometry(13'd1000, 13'd300, 16'd400); end
        default: begin
          w = $urandom_range(4096, 2);
          h = $urandom_range(4096, 2);
          set_geometry(13'(w), 13'(h), 16'($urandom_range(65535, 1)));
        end
      endcase
      if (phase == 2) hold_cycles = 400;
      send_random(200, w, h);
      drain_pipe();
    end

    $display("Sent %0d coordinates over eight geometries; %0d mapped inside the image.",
             sent, inside_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
